// File: rtl/kmd_pkg.sv
// Package: types, constants and keymap tables for the keyboard matrix debouncer.
package kmd_pkg;

    localparam int unsigned KB_ROWS  = 7;
    localparam int unsigned KB_COLS  = 5;
    localparam int unsigned KB_KEYS  = KB_ROWS * KB_COLS;
    localparam int unsigned KEY_IDXW = $clog2(KB_KEYS);

    localparam logic [7:0] KEY_ALT        = 8'h03;
    localparam logic [7:0] KEY_SYM        = 8'h01;
    localparam logic [7:0] KEY_NONE       = 8'h00;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

    typedef logic [KEY_IDXW-1:0] t_key_idx;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // One per-key entry of the state memory.
    typedef struct packed {
        logic        raw;
        logic        stable;
        logic [31:0] ctime;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // Keymaps, row major (index = row * KB_COLS + col).
    localparam logic [7:0] BASE_MAP [KB_KEYS] = '{
        8'h51, 8'h45, 8'h52, 8'h55, 8'h4F,
        8'h57, 8'h53, 8'h47, 8'h48, 8'h4C,
        8'h01, 8'h44, 8'h54, 8'h59, 8'h49,
        8'h41, 8'h50, 8'h02, 8'h0D, 8'h08,
        8'h03, 8'h58, 8'h56, 8'h42, 8'h06,
        8'h20, 8'h5A, 8'h43, 8'h4E, 8'h4D,
        8'h04, 8'h05, 8'h46, 8'h4A, 8'h4B
    };

    localparam logic [7:0] ALT_MAP [KB_KEYS] = '{
        8'h23, 8'h32, 8'h33, 8'h5F, 8'h2B,
        8'h31, 8'h34, 8'h2F, 8'h3A, 8'h22,
        8'h01, 8'h35, 8'h28, 8'h29, 8'h2D,
        8'h2A, 8'h40, 8'h02, 8'h0D, 8'h08,
        8'h03, 8'h38, 8'h3F, 8'h21, 8'h24,
        8'h20, 8'h37, 8'h39, 8'h27, 8'h2E,
        8'h30, 8'h05, 8'h36, 8'h3B, 8'h60
    };

    localparam logic [7:0] SYM_MAP [KB_KEYS] = '{
        8'h1B, 8'h5B, 8'h5D, 8'h00, 8'h3D,
        8'h11, 8'h13, 8'h7D, 8'h5E, 8'h00,
        8'h00, 8'h14, 8'h09, 8'h00, 8'h00,
        8'h12, 8'h25, 8'h0A, 8'h0D, 8'h7F,
        8'h08, 8'h3E, 8'h5C, 8'h00, 8'h06,
        8'h20, 8'h3C, 8'h07, 8'h7E, 8'h7C,
        8'h04, 8'h0A, 8'h7B, 8'h00, 8'h00
    };

endpackage

// File: rtl/kmd_in_if.sv
// Interface: input item channel (key sample, host read, host write).
interface kmd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  key_row;
    logic [2:0]  key_col;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, command, key_row, key_col, pin_level, now_ms,
                    input ready);
    modport sink   (input valid, command, key_row, key_col, pin_level, now_ms,
                    output ready);
endinterface

// File: rtl/kmd_out_if.sv
// Interface: result item channel.
interface kmd_out_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_data;
    logic       press_event;
    logic [7:0] press_code;
    logic       alt_active;
    logic       sym_active;

    modport source (output valid, read_valid, read_data, press_event, press_code,
                    alt_active, sym_active, input ready);
    modport sink   (input valid, read_valid, read_data, press_event, press_code,
                    alt_active, sym_active, output ready);
endinterface

// File: rtl/kmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/keyboard_matrix_debounce_layers_unit.sv
// Top level: 7x5 keyboard matrix debouncer with alt/sym keymap layers.
//
//  channel   dir  handshake         payload
//  i_in      in   valid / ready     command, key_row, key_col, pin_level, now_ms
//  o_out     out  valid / ready     read_valid, read_data, press_event, press_code,
//                                   alt_active, sym_active
//  i_cfg_*   in   write enable      debounce_time_ms (8 bits)
//
//  One item per cycle sustained while results are taken: the accept edge
//  registers the item and launches the state RAM read, and the pipeline
//  advance writes the result register. Result register stalls backpressure
//  the input (ready = result slot empty or being taken). Synchronous active-low
//  reset clears control state and the per-key valid bits; an entry whose valid
//  bit is clear reads as released with time zero, so no clearing pass.
module keyboard_matrix_debounce_layers_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    kmd_in_if.sink     i_in,
    kmd_out_if.source  o_out
);
    import kmd_pkg::*;

    // Pipeline advance: result slot free or drained this cycle.
    logic advance;

    // Debounce time register.
    logic [7:0] r_debounce;

    // Stage 1: registered item.
    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    t_key_idx    r_s1_idx;
    logic        r_s1_inrange;
    logic        r_s1_down;
    logic [31:0] r_s1_now;

    // Held flags and latched keycode.
    logic       r_alt, n_alt;
    logic       r_sym, n_sym;
    logic [7:0] r_latched, n_latched;

    // Per-key valid bits (entry written since reset).
    logic [KB_KEYS-1:0] r_ent_vld;

    // Write forwarding: the RAM read launched at the edge that also writes
    // the same key returns the old word.
    logic     r_fwd_valid;
    t_key_idx r_fwd_idx;
    t_entry   r_fwd_entry;

    // Result register.
    logic       r_out_valid;
    logic       r_out_rv;
    logic [7:0] r_out_rd;
    logic       r_out_pe;
    logic [7:0] r_out_pc;
    logic       r_out_alt;
    logic       r_out_sym;

    // Combinational.
    t_key_idx    in_idx;
    logic        in_inrange;
    logic [ENTRY_W-1:0] ram_q;
    t_entry      ent_cur, ent_new;
    logic        is_sample, is_read, ram_we;
    logic [31:0] age;
    logic        accept_chg, press;
    logic [7:0]  base_code, alt_code, sym_code, press_code;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = advance;

    // row * 5 + col
    assign in_idx     = KEY_IDXW'({i_in.key_row, 2'b00}) + KEY_IDXW'(i_in.key_row)
                      + KEY_IDXW'(i_in.key_col);
    assign in_inrange = (i_in.key_row < 3'(KB_ROWS)) && (i_in.key_col < 3'(KB_COLS));

    kmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KB_KEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (ent_new),
        .i_re    (advance),
        .i_raddr (in_idx),
        .o_rdata (ram_q)
    );

    // Current entry: forwarded word, else RAM word, else reset value.
    always_comb begin
        if (r_fwd_valid && (r_fwd_idx == r_s1_idx)) begin
            ent_cur = r_fwd_entry;
        end else if (r_ent_vld[r_s1_idx]) begin
            ent_cur = t_entry'(ram_q);
        end else begin
            ent_cur = '0;
        end
    end

    assign is_sample = r_s1_valid && (r_s1_cmd == CMD_SAMPLE) && r_s1_inrange;
    assign is_read   = r_s1_valid && (r_s1_cmd == CMD_READ);
    assign ram_we    = advance && is_sample;

    assign base_code = BASE_MAP[r_s1_idx];
    assign alt_code  = ALT_MAP[r_s1_idx];
    assign sym_code  = SYM_MAP[r_s1_idx];

    // Debounce: restart the timer on a raw change, accept once stable long enough.
    always_comb begin
        ent_new.raw    = r_s1_down;
        ent_new.ctime  = (r_s1_down != ent_cur.raw) ? r_s1_now : ent_cur.ctime;
        age            = r_s1_now - ent_new.ctime;
        accept_chg     = is_sample && (age >= {24'd0, r_debounce})
                         && (ent_new.raw != ent_cur.stable);
        ent_new.stable = accept_chg ? ent_new.raw : ent_cur.stable;
    end

    // Modifier flags, layer resolution, latch.
    always_comb begin
        n_alt = r_alt;
        n_sym = r_sym;
        if (accept_chg && (base_code == KEY_ALT)) begin
            n_alt = ent_new.raw;
        end else if (accept_chg && (base_code == KEY_SYM)) begin
            n_sym = ent_new.raw;
        end
        press = accept_chg && ent_new.raw;
        if (n_sym && (sym_code != KEY_NONE)) begin
            press_code = sym_code;
        end else if (n_alt) begin
            press_code = alt_code;
        end else begin
            press_code = base_code;
        end
        n_latched = r_latched;
        if (is_read) begin
            n_latched = KEY_NONE;
        end else if (press) begin
            n_latched = press_code;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_ent_vld   <= '0;
            r_alt       <= 1'b0;
            r_sym       <= 1'b0;
            r_latched   <= KEY_NONE;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (advance) begin
                r_s1_valid  <= i_in.valid;
                r_out_valid <= r_s1_valid;
                r_fwd_valid <= ram_we;
                r_alt       <= n_alt;
                r_sym       <= n_sym;
                r_latched   <= n_latched;
                if (ram_we) begin
                    r_ent_vld[r_s1_idx] <= 1'b1;
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd     <= t_cmd'(i_in.command);
            r_s1_idx     <= in_idx;
            r_s1_inrange <= in_inrange;
            r_s1_down    <= !i_in.pin_level;
            r_s1_now     <= i_in.now_ms;
            r_fwd_idx    <= r_s1_idx;
            r_fwd_entry  <= ent_new;
            r_out_rv     <= is_read;
            r_out_rd     <= is_read ? r_latched : KEY_NONE;
            r_out_pe     <= press;
            r_out_pc     <= press ? press_code : KEY_NONE;
            r_out_alt    <= n_alt;
            r_out_sym    <= n_sym;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_valid  = r_out_rv;
    assign o_out.read_data   = r_out_rd;
    assign o_out.press_event = r_out_pe;
    assign o_out.press_code  = r_out_pc;
    assign o_out.alt_active  = r_out_alt;
    assign o_out.sym_active  = r_out_sym;

    // A host read leaves the latch empty.
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_read) |=> (r_latched == KEY_NONE))
        else $error("latched code not cleared by host read");

    // Every resolved press has a nonzero keycode.
    a_press_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.press_event) |-> (o_out.press_code != KEY_NONE))
        else $error("press with zero keycode");

    // A result is never both a read answer and a press.
    a_rv_pe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.read_valid && o_out.press_event))
        else $error("read and press in one result");

    // The forwarded word always matches a key that was written.
    a_fwd_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_ent_vld[r_fwd_idx])
        else $error("forwarded entry without valid bit");

endmodule

// File: sim/tb_keyboard_matrix_debounce_layers_unit.sv
// Testbench for the keyboard matrix debouncer: directed and scan-based random stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_keyboard_matrix_debounce_layers_unit;
    import kmd_pkg::*;

    // Hard stop.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // Extra settle time after the last queued report has come back.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned IDLE_MAX = 13;
    localparam int unsigned ITEMS_PER_PHASE = 190;

    // One input item as the sender sees it.
    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        pin;
        logic [31:0] now;
    } t_kbd_item;

    // One result item; field order follows the result channel.
    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic       press_event;
        logic [7:0] press_code;
        logic       alt_active;
        logic       sym_active;
    } t_key_report;

    // Scoreboard: mirrors the per-key debounce state, the modifier flags and the
    // latched keycode, and queues the report each accepted item must produce.
    class kbd_scoreboard;
        logic        raw_lvl    [KB_KEYS];
        logic        stable_lvl [KB_KEYS];
        logic [31:0] change_ms  [KB_KEYS];
        logic        alt_on;
        logic        sym_on;
        logic [7:0]  last_code;
        logic [7:0]  db_window;
        t_key_report want_q [$];
        int unsigned errors;
        int unsigned items_taken;
        int unsigned presses;
        int unsigned reads;
        int unsigned settings;

        function new();
            for (int k = 0; k < KB_KEYS; k++) begin
                raw_lvl[k]    = 1'b0;
                stable_lvl[k] = 1'b0;
                change_ms[k]  = '0;
            end
            alt_on      = 1'b0;
            sym_on      = 1'b0;
            last_code   = KEY_NONE;
            db_window   = DEBOUNCE_RESET;
            errors      = 0;
            items_taken = 0;
            presses     = 0;
            reads       = 0;
            settings    = 1;
        endfunction

        function void set_debounce(logic [7:0] v);
            db_window = v;
            settings++;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // Work out the report for one accepted item and queue it.
        function void take_item(t_kbd_item it);
            t_key_report rep;
            int          k;
            logic        down;
            logic [31:0] age;
            logic [7:0]  code;
            rep = '0;
            items_taken++;
            if (it.cmd == CMD_READ) begin
                rep.read_valid = 1'b1;
                rep.read_data  = last_code;
                last_code      = KEY_NONE;
                reads++;
            end else if (it.cmd == CMD_SAMPLE && it.row < KB_ROWS && it.col < KB_COLS) begin
                k    = int'(it.row) * KB_COLS + int'(it.col);
                down = ~it.pin;
                if (down != raw_lvl[k]) begin
                    raw_lvl[k]   = down;
                    change_ms[k] = it.now;
                end
                age = it.now - change_ms[k];
                if (age >= {24'd0, db_window} && raw_lvl[k] != stable_lvl[k]) begin
                    stable_lvl[k] = raw_lvl[k];
                    if (BASE_MAP[k] == KEY_ALT) begin
                        alt_on = down;
                    end else if (BASE_MAP[k] == KEY_SYM) begin
                        sym_on = down;
                    end
                    if (down) begin
                        // sym layer wins unless its entry is empty, then alt, then base
                        if (sym_on && SYM_MAP[k] != KEY_NONE) begin
                            code = SYM_MAP[k];
                        end else if (alt_on) begin
                            code = ALT_MAP[k];
                        end else begin
                            code = BASE_MAP[k];
                        end
                        last_code       = code;
                        rep.press_event = 1'b1;
                        rep.press_code  = code;
                        presses++;
                    end
                end
            end
            rep.alt_active = alt_on;
            rep.sym_active = sym_on;
            want_q.push_back(rep);
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest queued report.
        function void check_report(t_key_report got);
            t_key_report want;
            if (want_q.size() == 0) begin
                $error("result with no item pending: %p", got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            cmp_field("read_valid",  8'(want.read_valid),  8'(got.read_valid));
            cmp_field("read_data",   want.read_data,       got.read_data);
            cmp_field("press_event", 8'(want.press_event), 8'(got.press_event));
            cmp_field("press_code",  want.press_code,      got.press_code);
            cmp_field("alt_active",  8'(want.alt_active),  8'(got.alt_active));
            cmp_field("sym_active",  8'(want.sym_active),  8'(got.sym_active));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    int unsigned cycle_count = 0;

    // Shared switch: when set, neither side inserts idle cycles.
    bit          no_idle = 1'b0;
    // Time base of the scan, and which keys the "user" is holding down.
    logic [31:0] scan_ms;
    bit          key_held [KB_KEYS];

    kbd_scoreboard sb = new();

    kmd_in_if  in_ch ();
    kmd_out_if out_ch ();

    keyboard_matrix_debounce_layers_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_kbd_item kbd_item(t_cmd cmd, int row, int col, bit pin,
                                           logic [31:0] now);
        t_kbd_item it;
        it.cmd = cmd;
        it.row = 3'(row);
        it.col = 3'(col);
        it.pin = pin;
        it.now = now;
        return it;
    endfunction

    // Anything goes: all commands, rows and columns past the matrix, any time.
    function automatic t_kbd_item noise_item();
        t_kbd_item it;
        it.cmd = t_cmd'($urandom_range(0, 3));
        it.row = 3'($urandom_range(0, 7));
        it.col = 3'($urandom_range(0, 7));
        it.pin = 1'($urandom_range(0, 1));
        it.now = $urandom();
        return it;
    endfunction

    // Items the block does real work on: reads and in-range samples.
    function automatic bit does_work(t_kbd_item it);
        return it.cmd == CMD_READ ||
               (it.cmd == CMD_SAMPLE && it.row < KB_ROWS && it.col < KB_COLS);
    endfunction

    // Called at a rising edge; returns at the edge that accepted the item.
    // With no gap, valid stays high straight into the next item.
    task automatic send_item(input t_kbd_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= it.cmd;
        in_ch.key_row   <= it.row;
        in_ch.key_col   <= it.col;
        in_ch.pin_level <= it.pin;
        in_ch.now_ms    <= it.now;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_item(it);
    endtask

    // Sender holds off until every queued report has come back, then lets the
    // pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_debounce(input logic [7:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_debounce(v);
    endtask

    // Random phase. Mostly full scan frames in matrix order, with keys held and
    // released over time, contact bounce on the pin, and host reads mixed in;
    // now and then a short burst of noise.
    task automatic run_scans(input int unsigned n_items, input logic [7:0] db);
        int unsigned count;
        int unsigned step_max;
        t_kbd_item   it;
        count    = 0;
        step_max = db / 3 + 2;
        while (count < n_items) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    it = noise_item();
                    send_item(it);
                    if (does_work(it)) count++;
                end
            end else begin
                scan_ms += $urandom_range(0, step_max);
                for (int k = 0; k < KB_KEYS; k++) begin
                    if ($urandom_range(0, 15) == 0) key_held[k] = !key_held[k];
                    // pin is active low; occasional bounce flips the reading
                    it = kbd_item(CMD_SAMPLE, k / KB_COLS, k % KB_COLS, !key_held[k],
                                  scan_ms);
                    if ($urandom_range(0, 9) == 0) it.pin = !it.pin;
                    send_item(it);
                    count++;
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(kbd_item(CMD_READ, 0, 0, 1'b1, scan_ms));
                        count++;
                    end
                    if ($urandom_range(0, 7) == 0) scan_ms += 1;
                end
            end
        end
    endtask

    // Result side: random stall before each result, ready held until it is taken.
    initial begin
        int unsigned stall;
        t_key_report got;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.read_valid  = out_ch.read_valid;
            got.read_data   = out_ch.read_data;
            got.press_event = out_ch.press_event;
            got.press_code  = out_ch.press_code;
            got.alt_active  = out_ch.alt_active;
            got.sym_active  = out_ch.sym_active;
            sb.check_report(got);
        end
    end

    // Main sequence.
    initial begin
        logic [7:0] db;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_SAMPLE;
        in_ch.key_row   <= '0;
        in_ch.key_col   <= '0;
        in_ch.pin_level <= 1'b1;
        in_ch.now_ms    <= '0;
        foreach (key_held[k]) key_held[k] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, debounce at its reset value of 10 ms ---
        send_item(kbd_item(CMD_READ,   0, 0, 1'b1, 32'd0));     // nothing latched yet
        send_item(kbd_item(CMD_SAMPLE, 0, 0, 1'b0, 32'd100));   // raw press, too early
        send_item(kbd_item(CMD_SAMPLE, 0, 0, 1'b0, 32'd110));   // stable: base layer
        send_item(kbd_item(CMD_READ,   0, 0, 1'b1, 32'd111));   // returns code ...
        send_item(kbd_item(CMD_READ,   0, 0, 1'b1, 32'd112));   // ... and clears it
        send_item(kbd_item(CMD_SAMPLE, 4, 0, 1'b0, 32'd200));   // alt key down
        send_item(kbd_item(CMD_SAMPLE, 4, 0, 1'b0, 32'd210));
        send_item(kbd_item(CMD_SAMPLE, 0, 1, 1'b0, 32'd300));   // alt layer press
        send_item(kbd_item(CMD_SAMPLE, 0, 1, 1'b0, 32'd310));
        send_item(kbd_item(CMD_SAMPLE, 2, 0, 1'b0, 32'd400));   // sym key, alt still held
        send_item(kbd_item(CMD_SAMPLE, 2, 0, 1'b0, 32'd410));
        send_item(kbd_item(CMD_SAMPLE, 0, 3, 1'b0, 32'd500));   // empty sym entry -> alt
        send_item(kbd_item(CMD_SAMPLE, 0, 3, 1'b0, 32'd510));
        send_item(kbd_item(CMD_SAMPLE, 4, 0, 1'b1, 32'd600));   // release alt: flag only
        send_item(kbd_item(CMD_SAMPLE, 4, 0, 1'b1, 32'd610));
        send_item(kbd_item(CMD_SAMPLE, 1, 1, 1'b0, 32'd700));   // bouncing contact
        send_item(kbd_item(CMD_SAMPLE, 1, 1, 1'b1, 32'd705));
        send_item(kbd_item(CMD_SAMPLE, 1, 1, 1'b0, 32'd708));
        send_item(kbd_item(CMD_SAMPLE, 1, 1, 1'b0, 32'd718));
        send_item(kbd_item(CMD_WRITE,  1, 2, 1'b0, 32'd720));   // host write ignored
        send_item(kbd_item(CMD_UNUSED, 1, 2, 1'b0, 32'd721));   // unused command ignored
        send_item(kbd_item(CMD_SAMPLE, 7, 0, 1'b0, 32'd722));   // row past the matrix
        send_item(kbd_item(CMD_SAMPLE, 0, 5, 1'b0, 32'd723));   // column past the matrix
        send_item(kbd_item(CMD_SAMPLE, 6, 4, 1'b0, 32'hFFFF_FFFA)); // time wraps ...
        send_item(kbd_item(CMD_SAMPLE, 6, 4, 1'b0, 32'h0000_0004)); // ... 10 ms later

        // zero debounce: a change is taken in the same sample
        write_debounce(8'd0);
        send_item(kbd_item(CMD_SAMPLE, 1, 0, 1'b0, 32'hFFFF_FFFF));
        send_item(kbd_item(CMD_SAMPLE, 2, 0, 1'b1, 32'hFFFF_FFFF));
        send_item(kbd_item(CMD_READ,   0, 0, 1'b1, 32'd0));

        // --- random phases over several debounce settings, extremes included ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: db = 8'd0;
                1: db = DEBOUNCE_RESET;
                2: db = 8'd255;
                3: db = 8'd1;
                4: db = 8'($urandom_range(2, 254));
                default: db = 8'd3;
            endcase
            write_debounce(db);
            // one phase runs across the 32-bit time wrap
            scan_ms = (p == 2) ? 32'hFFFF_FF00 : $urandom();
            run_scans(ITEMS_PER_PHASE, db);
        end

        drain();
        $display("Run covered %0d items (%0d presses, %0d host reads) over %0d debounce settings",
                 sb.items_taken, sb.presses, sb.reads, sb.settings);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: keyboard_matrix_debounce_layers_unit.f
rtl/kmd_pkg.sv
rtl/kmd_in_if.sv
rtl/kmd_out_if.sv
rtl/kmd_ram.sv
rtl/keyboard_matrix_debounce_layers_unit.sv
sim/tb_keyboard_matrix_debounce_layers_unit.sv
